>>> rtl/wsp_pkg.sv
// Types and constants shared by the wall segment projector modules
package wsp_pkg;

    // register indexes of the configuration port
    typedef enum logic [2:0] {
        CFG_SCREEN_DIST = 3'd0,
        CFG_VANISH_OFS  = 3'd1,
        CFG_WALL_HEIGHT = 3'd2,
        CFG_SCREEN_LEFT = 3'd3,
        CFG_SCREEN_RIGHT = 3'd4
    } t_cfg_idx;

    localparam int CFG_IDX_W = 3;

    // clip side codes
    localparam logic [1:0] CLIP_NONE  = 2'd0;
    localparam logic [1:0] CLIP_LEFT  = 2'd1;
    localparam logic [1:0] CLIP_RIGHT = 2'd2;

    // divider geometry
    localparam int CUT_NUM_W = 31;
    localparam int CUT_DEN_W = 16;
    localparam int CUT_Q_W   = 16;
    localparam int PRJ_NUM_W = 46;
    localparam int PRJ_DEN_W = 17;
    localparam int PX_Q_W    = 42;
    localparam int HT_Q_W    = 32;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic [15:0]        tag;
    } t_seg_in;

    typedef struct packed {
        logic               visible;
        logic signed [31:0] left_x;
        logic signed [31:0] right_x;
        logic signed [31:0] left_height;
        logic signed [31:0] right_height;
        logic [33:0]        far_dist_sq;
        logic [33:0]        near_dist_sq;
        logic [1:0]         clip_side;
        logic [15:0]        tag_out;
    } t_seg_out;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] bx;
        logic signed [15:0] by;
    } t_coord;

endpackage

>>> rtl/wsp_div.sv
// Pipelined restoring divider, one quotient bit per stage, sign applied at the end
module wsp_div
    import wsp_pkg::*;
#(
    parameter int NW = 46,
    parameter int DW = 17,
    parameter int QW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic          i_neg,
    input  logic          i_zero,
    output logic [QW-1:0] o_quo
);

    logic [DW-1:0] r_rem  [0:NW];
    logic [NW-1:0] r_num  [0:NW];
    logic [QW-1:0] r_q    [0:NW];
    logic [DW-1:0] r_den  [0:NW];
    logic          r_neg  [0:NW];
    logic          r_zero [0:NW];

    logic [DW-1:0] n_rem [1:NW];
    logic [NW-1:0] n_num [1:NW];
    logic [QW-1:0] n_q   [1:NW];

    always_comb begin
        logic [DW:0] trial;
        logic        ge;
        for (int k = 1; k <= NW; k++) begin
            trial    = {r_rem[k-1], r_num[k-1][NW-1]};
            ge       = (trial >= {1'b0, r_den[k-1]});
            n_rem[k] = ge ? DW'(trial - {1'b0, r_den[k-1]}) : trial[DW-1:0];
            n_num[k] = {r_num[k-1][NW-2:0], 1'b0};
            n_q[k]   = {r_q[k-1][QW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_num[0]  <= i_num;
            r_q[0]    <= '0;
            r_den[0]  <= i_den;
            r_neg[0]  <= i_neg;
            r_zero[0] <= i_zero;
            for (int k = 1; k <= NW; k++) begin
                r_rem[k]  <= n_rem[k];
                r_num[k]  <= n_num[k];
                r_q[k]    <= n_q[k];
                r_den[k]  <= r_den[k-1];
                r_neg[k]  <= r_neg[k-1];
                r_zero[k] <= r_zero[k-1];
            end
        end
    end

    // division by zero yields zero
    assign o_quo = r_zero[NW] ? '0 : (r_neg[NW] ? QW'(-r_q[NW]) : r_q[NW]);

endmodule

>>> rtl/wall_segment_projector.sv
// Wall segment projector: near-plane cut, distances and perspective projection
//
// Input channel i_seg / i_seg_valid / o_seg_stall carries one wall segment per
// item in view space (16.16 style endpoints and a tag). Output channel o_res /
// o_res_valid / i_res_stall returns one result item per segment, in order.
// Registers are written through i_cfg_valid / o_cfg_ready (always ready),
// i_cfg_index and i_cfg_data. The user must write them only while no
// segment is in flight; the block itself does not enforce this. Throughput: one
// segment per cycle while o_seg_stall is low. A 32-stage divider for the
// cut point and a 47-stage divider for the projection, one quotient bit per
// stage, lie on the path, with the multiply, compare and output stages.
// Reset clears all valid bits and loads the register defaults.
// When the receiver stalls, the output register holds and one more item lands
// in a skid register; the pipeline then freezes and o_seg_stall rises until
// the skid register has drained.
module wall_segment_projector
    import wsp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_seg_in              i_seg,
    input  logic                 i_seg_valid,
    output logic                 o_seg_stall,
    output t_seg_out             o_res,
    output logic                 o_res_valid,
    input  logic                 i_res_stall,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int LAT_C = CUT_NUM_W + 1;
    localparam int LAT_P = PRJ_NUM_W + 1;

    typedef struct packed {
        t_coord      c;
        logic [1:0]  cut;
        logic [15:0] tag;
    } t_csb;

    typedef struct packed {
        logic [33:0] far_d;
        logic [33:0] near_d;
        logic [1:0]  cut;
        logic        front;
        logic [15:0] tag;
    } t_psb;

    // configuration
    logic [15:0]        r_screen_dist;
    logic signed [16:0] r_vanish;
    logic [15:0]        r_wall_h;
    logic signed [31:0] r_scr_left;
    logic [30:0]        r_scr_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_dist <= 16'd256;
            r_vanish      <= -17'sd256;
            r_wall_h      <= 16'd64;
            r_scr_left    <= -32'sd1310720;
            r_scr_right   <= 31'd1310720;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_SCREEN_DIST:  r_screen_dist <= i_cfg_data[15:0];
                CFG_VANISH_OFS:   r_vanish      <= i_cfg_data[16:0];
                CFG_WALL_HEIGHT:  r_wall_h      <= i_cfg_data[15:0];
                CFG_SCREEN_LEFT:  r_scr_left    <= i_cfg_data;
                CFG_SCREEN_RIGHT: r_scr_right   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // pipeline advance
    logic r_skid_full;
    logic en;
    logic accept;

    assign en          = !r_skid_full;
    assign o_seg_stall = r_skid_full;
    assign accept      = i_seg_valid && en;

    // valid bits
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid, r_e_valid, r_g_valid, r_h_valid;
    logic r_cv [0:LAT_C-1];
    logic r_pv [0:LAT_P-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_g_valid <= 1'b0;
            r_h_valid <= 1'b0;
            for (int k = 0; k < LAT_C; k++) r_cv[k] <= 1'b0;
            for (int k = 0; k < LAT_P; k++) r_pv[k] <= 1'b0;
        end else if (en) begin
            r_a_valid <= accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_cv[0]   <= r_c_valid;
            for (int k = 1; k < LAT_C; k++) r_cv[k] <= r_cv[k-1];
            r_d_valid <= r_cv[LAT_C-1];
            r_e_valid <= r_d_valid;
            r_pv[0]   <= r_e_valid;
            for (int k = 1; k < LAT_P; k++) r_pv[k] <= r_pv[k-1];
            r_g_valid <= r_pv[LAT_P-1];
            r_h_valid <= r_g_valid;
        end
    end

    // stage A: floor shift by 16 is the upper half
    t_coord      r_a_c;
    logic [15:0] r_a_tag;

    // stage B: cut decision and multiplier operands
    t_coord             r_b_c;
    logic [1:0]         r_b_cut;
    logic [15:0]        r_b_tag;
    logic signed [15:0] r_b_ma;
    logic signed [16:0] r_b_mb;
    logic [15:0]        r_b_den;

    logic               cut2, cut1;
    logic signed [16:0] diff_ba, diff_ab, den_ab, den_ba;
    logic [1:0]         n_cut;
    logic signed [15:0] n_ma;
    logic signed [16:0] n_mb;
    logic [15:0]        n_den;

    always_comb begin
        cut2    = (r_a_c.ay > 16'sd0) && (r_a_c.by < 16'sd0);
        cut1    = (r_a_c.by > 16'sd0) && (r_a_c.ay < 16'sd0);
        diff_ba = {r_a_c.bx[15], r_a_c.bx} - {r_a_c.ax[15], r_a_c.ax};
        diff_ab = {r_a_c.ax[15], r_a_c.ax} - {r_a_c.bx[15], r_a_c.bx};
        den_ab  = {r_a_c.ay[15], r_a_c.ay} - {r_a_c.by[15], r_a_c.by};
        den_ba  = {r_a_c.by[15], r_a_c.by} - {r_a_c.ay[15], r_a_c.ay};
        if (cut2) begin
            n_cut = CLIP_RIGHT;
            n_ma  = r_a_c.ay;
            n_mb  = diff_ba;
            n_den = den_ab[15:0];
        end else if (cut1) begin
            n_cut = CLIP_LEFT;
            n_ma  = r_a_c.by;
            n_mb  = diff_ab;
            n_den = den_ba[15:0];
        end else begin
            n_cut = CLIP_NONE;
            n_ma  = '0;
            n_mb  = '0;
            n_den = 16'd1;
        end
    end

    // stage C: cut product
    t_coord             r_c_c;
    logic [1:0]         r_c_cut;
    logic [15:0]        r_c_tag;
    logic signed [32:0] r_c_prod;
    logic [15:0]        r_c_den;
    logic signed [32:0] n_prod;
    logic [32:0]        c_abs;

    assign n_prod = r_b_ma * r_b_mb;
    assign c_abs  = r_c_prod[32] ? 33'(-r_c_prod) : r_c_prod;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_c.ax <= i_seg.start_x[31:16];
            r_a_c.ay <= i_seg.start_y[31:16];
            r_a_c.bx <= i_seg.end_x[31:16];
            r_a_c.by <= i_seg.end_y[31:16];
            r_a_tag  <= i_seg.tag;
            r_b_c    <= r_a_c;
            r_b_tag  <= r_a_tag;
            r_b_cut  <= n_cut;
            r_b_ma   <= n_ma;
            r_b_mb   <= n_mb;
            r_b_den  <= n_den;
            r_c_c    <= r_b_c;
            r_c_tag  <= r_b_tag;
            r_c_cut  <= r_b_cut;
            r_c_prod <= n_prod;
            r_c_den  <= r_b_den;
        end
    end

    // cut-point divider
    logic [CUT_Q_W-1:0] cut_q;

    wsp_div #(.NW(CUT_NUM_W), .DW(CUT_DEN_W), .QW(CUT_Q_W)) u_cut_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (c_abs[CUT_NUM_W-1:0]),
        .i_den  (r_c_den),
        .i_neg  (r_c_prod[32]),
        .i_zero (r_c_den == '0),
        .o_quo  (cut_q)
    );

    t_csb r_csb [0:LAT_C-1];

    // stage D: apply cut
    t_coord      r_d_c;
    logic [1:0]  r_d_cut;
    logic [15:0] r_d_tag;
    t_coord      n_dc;
    t_csb        csb_o;

    assign csb_o = r_csb[LAT_C-1];

    always_comb begin
        n_dc = csb_o.c;
        if (csb_o.cut == CLIP_RIGHT) begin
            n_dc.bx = csb_o.c.ax + $signed(cut_q);
            n_dc.by = '0;
        end else if (csb_o.cut == CLIP_LEFT) begin
            n_dc.ax = csb_o.c.bx + $signed(cut_q);
            n_dc.ay = '0;
        end
    end

    // stage E: squares and projection products
    logic signed [17:0] scale;
    logic signed [31:0] sq_ax, sq_ay, sq_bx, sq_by;
    logic signed [33:0] n_ppa, n_ppb;
    logic signed [34:0] n_ph;
    logic signed [17:0] n_dena, n_denb;

    assign scale  = $signed({2'b00, r_screen_dist}) - $signed({r_vanish[16], r_vanish});
    assign sq_ax  = r_d_c.ax * r_d_c.ax;
    assign sq_ay  = r_d_c.ay * r_d_c.ay;
    assign sq_bx  = r_d_c.bx * r_d_c.bx;
    assign sq_by  = r_d_c.by * r_d_c.by;
    assign n_ppa  = r_d_c.ax * scale;
    assign n_ppb  = r_d_c.bx * scale;
    assign n_ph   = $signed({1'b0, r_wall_h}) * scale;
    assign n_dena = {{2{r_d_c.ay[15]}}, r_d_c.ay} - {r_vanish[16], r_vanish};
    assign n_denb = {{2{r_d_c.by[15]}}, r_d_c.by} - {r_vanish[16], r_vanish};

    logic [30:0]        r_e_sqax, r_e_sqay, r_e_sqbx, r_e_sqby;
    logic signed [33:0] r_e_ppa, r_e_ppb;
    logic signed [34:0] r_e_ph;
    logic signed [17:0] r_e_dena, r_e_denb;
    logic               r_e_front;
    logic [1:0]         r_e_cut;
    logic [15:0]        r_e_tag;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_csb[0].c   <= r_c_c;
            r_csb[0].cut <= r_c_cut;
            r_csb[0].tag <= r_c_tag;
            for (int k = 1; k < LAT_C; k++) r_csb[k] <= r_csb[k-1];
            r_d_c     <= n_dc;
            r_d_cut   <= csb_o.cut;
            r_d_tag   <= csb_o.tag;
            r_e_sqax  <= sq_ax[30:0];
            r_e_sqay  <= sq_ay[30:0];
            r_e_sqbx  <= sq_bx[30:0];
            r_e_sqby  <= sq_by[30:0];
            r_e_ppa   <= n_ppa;
            r_e_ppb   <= n_ppb;
            r_e_ph    <= n_ph;
            r_e_dena  <= n_dena;
            r_e_denb  <= n_denb;
            r_e_front <= !r_d_c.ay[15] && !r_d_c.by[15];
            r_e_cut   <= r_d_cut;
            r_e_tag   <= r_d_tag;
        end
    end

    // stage F (into divider stage 0): distances and divider operands
    logic [31:0] sum_a, sum_b;
    logic [33:0] dist_a, dist_b;
    logic [33:0] abs_pa, abs_pb;
    logic [34:0] abs_h;
    logic [17:0] abs_da, abs_db;
    t_psb        n_psb;

    always_comb begin
        sum_a  = {1'b0, r_e_sqax} + {1'b0, r_e_sqay};
        sum_b  = {1'b0, r_e_sqbx} + {1'b0, r_e_sqby};
        dist_a = {sum_a, 2'b00};
        dist_b = {sum_b, 2'b00};
        abs_pa = r_e_ppa[33] ? 34'(-r_e_ppa) : r_e_ppa;
        abs_pb = r_e_ppb[33] ? 34'(-r_e_ppb) : r_e_ppb;
        abs_h  = r_e_ph[34] ? 35'(-r_e_ph) : r_e_ph;
        abs_da = r_e_dena[17] ? 18'(-r_e_dena) : r_e_dena;
        abs_db = r_e_denb[17] ? 18'(-r_e_denb) : r_e_denb;
        n_psb.far_d  = (dist_a < dist_b) ? dist_b : dist_a;
        n_psb.near_d = (dist_a < dist_b) ? dist_a : dist_b;
        n_psb.cut    = r_e_cut;
        n_psb.front  = r_e_front;
        n_psb.tag    = r_e_tag;
    end

    logic [PX_Q_W-1:0] q_pa, q_pb;
    logic [HT_Q_W-1:0] q_ha, q_hb;

    wsp_div #(.NW(PRJ_NUM_W), .DW(PRJ_DEN_W), .QW(PX_Q_W)) u_pa_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  ({5'b0, abs_pa[32:0], 8'b0}),
        .i_den  (abs_da[16:0]),
        .i_neg  (r_e_ppa[33] ^ r_e_dena[17]),
        .i_zero (r_e_dena == '0),
        .o_quo  (q_pa)
    );

    wsp_div #(.NW(PRJ_NUM_W), .DW(PRJ_DEN_W), .QW(PX_Q_W)) u_pb_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  ({5'b0, abs_pb[32:0], 8'b0}),
        .i_den  (abs_db[16:0]),
        .i_neg  (r_e_ppb[33] ^ r_e_denb[17]),
        .i_zero (r_e_denb == '0),
        .o_quo  (q_pb)
    );

    wsp_div #(.NW(PRJ_NUM_W), .DW(PRJ_DEN_W), .QW(HT_Q_W)) u_ha_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  ({1'b0, abs_h[32:0], 12'b0}),
        .i_den  (abs_da[16:0]),
        .i_neg  (r_e_ph[34] ^ r_e_dena[17]),
        .i_zero (r_e_dena == '0),
        .o_quo  (q_ha)
    );

    wsp_div #(.NW(PRJ_NUM_W), .DW(PRJ_DEN_W), .QW(HT_Q_W)) u_hb_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  ({1'b0, abs_h[32:0], 12'b0}),
        .i_den  (abs_db[16:0]),
        .i_neg  (r_e_ph[34] ^ r_e_denb[17]),
        .i_zero (r_e_denb == '0),
        .o_quo  (q_hb)
    );

    t_psb r_psb [0:LAT_P-1];

    // stage G: projected values
    logic signed [45:0] r_g_pa, r_g_pb;
    logic [31:0]        r_g_ha, r_g_hb;
    t_psb               r_g_sb;

    // stage H: order, screen overlap and clip code
    logic signed [45:0] sl46, sr46;
    logic               lt, vis;
    t_seg_out           n_h;
    t_seg_out           r_h;

    always_comb begin
        sl46 = {{14{r_scr_left[31]}}, r_scr_left};
        sr46 = {15'b0, r_scr_right};
        lt   = r_g_pa < r_g_pb;
        if (lt) begin
            vis = r_g_sb.front && (r_g_pa < sr46) && (r_g_pb > sl46);
        end else begin
            vis = r_g_sb.front && (r_g_pb < sr46) && (r_g_pa > sl46);
        end
        n_h.visible      = vis;
        n_h.far_dist_sq  = r_g_sb.far_d;
        n_h.near_dist_sq = r_g_sb.near_d;
        n_h.tag_out      = r_g_sb.tag;
        n_h.left_x       = '0;
        n_h.right_x      = '0;
        n_h.left_height  = '0;
        n_h.right_height = '0;
        n_h.clip_side    = CLIP_NONE;
        if (vis) begin
            if (lt) begin
                n_h.left_x       = r_g_pa[31:0];
                n_h.right_x      = r_g_pb[31:0];
                n_h.left_height  = r_g_ha;
                n_h.right_height = r_g_hb;
                n_h.clip_side    = (r_g_sb.cut == CLIP_RIGHT) ? CLIP_NONE : r_g_sb.cut;
            end else begin
                n_h.left_x       = r_g_pb[31:0];
                n_h.right_x      = r_g_pa[31:0];
                n_h.left_height  = r_g_hb;
                n_h.right_height = r_g_ha;
                n_h.clip_side    = (r_g_sb.cut == CLIP_LEFT) ? CLIP_NONE : r_g_sb.cut;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_psb[0] <= n_psb;
            for (int k = 1; k < LAT_P; k++) r_psb[k] <= r_psb[k-1];
            r_g_pa <= {q_pa, 4'b0000};
            r_g_pb <= {q_pb, 4'b0000};
            r_g_ha <= q_ha;
            r_g_hb <= q_hb;
            r_g_sb <= r_psb[LAT_P-1];
            r_h    <= n_h;
        end
    end

    // output register with skid
    t_seg_out r_out, r_skid;
    logic     r_out_valid;
    logic     out_free;

    assign out_free = !r_out_valid || !i_res_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_skid_full || (r_h_valid && en);
            r_skid_full <= 1'b0;
        end else if (r_h_valid && en) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_full ? r_skid : r_h;
        end else if (r_h_valid && en) begin
            r_skid <= r_h;
        end
    end

    assign o_res       = r_out;
    assign o_res_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_full |-> r_out_valid)
        else $error("skid register full while output register empty");

    a_far_ge_near: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.far_dist_sq >= o_res.near_dist_sq))
        else $error("far distance below near distance");

    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.visible) |->
            (o_res.clip_side == CLIP_NONE && o_res.left_x == '0 && o_res.right_x == '0))
        else $error("hidden segment carries projection data");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (!o_res_valid && !r_skid_full))
        else $error("result presented straight after reset");
`endif

endmodule

>>> tb/tb_wall_segment_projector.sv
// Self-checking testbench for the wall segment projector
module tb_wall_segment_projector;
    import wsp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                 i_clk;
    logic                 i_rst_n;
    t_seg_in              i_seg;
    logic                 i_seg_valid;
    logic                 o_seg_stall;
    t_seg_out             o_res;
    logic                 o_res_valid;
    logic                 i_res_stall;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    wall_segment_projector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg       (i_seg),
        .i_seg_valid (i_seg_valid),
        .o_seg_stall (o_seg_stall),
        .o_res       (o_res),
        .o_res_valid (o_res_valid),
        .i_res_stall (i_res_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // register copies
    longint screen_dist, vanish_ofs, wall_ht, scr_left, scr_right;

    t_seg_out pending_res[$];
    int       n_errors;
    bit       sender_idle_ok;   // sender may insert gaps
    bit       rx_idle_ok;       // receiver may stall at random
    bit       hold_req;
    bit       hold_taken;
    int       hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    function automatic longint div_or_zero(longint num, longint den);
        if (den == 0) return 0;
        return num / den;
    endfunction

    function automatic t_seg_out project_seg(t_seg_in s);
        longint   ax, ay, bx, by, da, db, t;
        longint   scale, hnum, pa, pb, ha, hb, lx, rx, lh, rh;
        logic [1:0] cut;
        bit       vis;
        t_seg_out r;
        // arithmetic shift gives the floor
        ax = longint'(s.start_x >>> 16);
        ay = longint'(s.start_y >>> 16);
        bx = longint'(s.end_x >>> 16);
        by = longint'(s.end_y >>> 16);
        cut = CLIP_NONE;
        vis = 0;
        lx = 0; rx = 0; lh = 0; rh = 0;
        if (ay > 0 && by < 0) begin
            cut = CLIP_RIGHT;
            bx = ax + (ay * (bx - ax)) / (ay - by);
            by = 0;
        end else if (by > 0 && ay < 0) begin
            cut = CLIP_LEFT;
            ax = bx + (by * (ax - bx)) / (by - ay);
            ay = 0;
        end
        da = (ax * ax + ay * ay) * 4;
        db = (bx * bx + by * by) * 4;
        if (da < db) begin
            t = da; da = db; db = t;
        end
        if (ay >= 0 && by >= 0) begin
            scale = screen_dist - vanish_ofs;
            hnum  = scale * wall_ht * 4096;
            pa = div_or_zero(ax * scale * 256, ay - vanish_ofs) * 16;
            pb = div_or_zero(bx * scale * 256, by - vanish_ofs) * 16;
            ha = div_or_zero(hnum, ay - vanish_ofs);
            hb = div_or_zero(hnum, by - vanish_ofs);
            if (pa < pb) begin
                if (cut == CLIP_RIGHT) cut = CLIP_NONE;
                if (pa < scr_right && pb > scr_left) begin
                    vis = 1;
                    lx = pa; rx = pb; lh = ha; rh = hb;
                end
            end else if (pb < scr_right && pa > scr_left) begin
                if (cut == CLIP_LEFT) cut = CLIP_NONE;
                vis = 1;
                lx = pb; rx = pa; lh = hb; rh = ha;
            end
        end
        if (!vis) begin
            cut = CLIP_NONE;
            lx = 0; rx = 0; lh = 0; rh = 0;
        end
        r.visible      = vis;
        r.left_x       = lx[31:0];
        r.right_x      = rx[31:0];
        r.left_height  = lh[31:0];
        r.right_height = rh[31:0];
        r.far_dist_sq  = da[33:0];
        r.near_dist_sq = db[33:0];
        r.clip_side    = cut;
        r.tag_out      = s.tag;
        return r;
    endfunction

    function automatic t_seg_in make_seg(int ax, int ay, int bx, int by, int tg);
        t_seg_in s;
        s.start_x = ax; s.start_y = ay; s.end_x = bx; s.end_y = by;
        s.tag = tg[15:0];
        return s;
    endfunction

    // mostly in-front segments of moderate size, some crossing, some noise
    function automatic t_seg_in rand_seg();
        t_seg_in s;
        int      mode;
        mode = $urandom_range(0, 9);
        s.tag = 16'($urandom);
        if (mode < 2) begin
            s.start_x = $urandom; s.start_y = $urandom;
            s.end_x   = $urandom; s.end_y   = $urandom;
        end else begin
            s.start_x = int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            s.end_x   = int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            s.start_y = $urandom_range(0, 32'h0100_0000);
            s.end_y   = $urandom_range(0, 32'h0100_0000);
            if (mode >= 8) begin
                if ($urandom_range(0, 1)) s.end_y = -s.end_y - 32'sh1_0000;
                else s.start_y = -s.start_y - 32'sh1_0000;
            end
        end
        return s;
    endfunction

    task automatic pause_cycles(int n);
        repeat (n) @(negedge i_clk);
    endtask

    task automatic send_seg(t_seg_in s);
        int r;
        @(negedge i_clk);
        i_seg = s;
        i_seg_valid = 1'b1;
        do @(posedge i_clk); while (o_seg_stall);
        pending_res.push_back(project_seg(s));
        if (sender_idle_ok) begin
            r = $urandom_range(0, 99);
            if (r >= 60) begin
                @(negedge i_clk);
                i_seg_valid = 1'b0;
                i_seg = rand_seg();
                pause_cycles(r >= 92 ? $urandom_range(5, 30) : $urandom_range(0, 2));
            end
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_seg_valid = 1'b0;
        while (pending_res.size() != 0) @(negedge i_clk);
        pause_cycles(100);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SCREEN_DIST:  screen_dist = longint'(data[15:0]);
            CFG_VANISH_OFS:   vanish_ofs  = longint'($signed(data[16:0]));
            CFG_WALL_HEIGHT:  wall_ht     = longint'(data[15:0]);
            CFG_SCREEN_LEFT:  scr_left    = longint'($signed(data));
            CFG_SCREEN_RIGHT: scr_right   = longint'(data[30:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_view(int sd, int vo, int wh, int sl, int sr);
        write_reg(CFG_SCREEN_DIST, sd);
        write_reg(CFG_VANISH_OFS, vo);
        write_reg(CFG_WALL_HEIGHT, wh);
        write_reg(CFG_SCREEN_LEFT, sl);
        write_reg(CFG_SCREEN_RIGHT, sr);
    endtask

    task automatic send_random(int n);
        repeat (n) send_seg(rand_seg());
    endtask

    task automatic test_directed();
        sender_idle_ok = 0;
        send_seg(make_seg(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'hffff));
        send_seg(make_seg(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
        send_seg(make_seg(0, 0, 0, 0, 16'h5a5a));
        send_seg(make_seg(-1, -1, 32'hffff, 32'hffff, 1));
        send_seg(make_seg(-32'sh10_0000, 32'sh20_0000, 32'sh10_0000, 32'sh30_0000, 2));
        send_seg(make_seg(32'sh10_0000, 32'sh20_0000, -32'sh10_0000, 32'sh30_0000, 3));
        // crossing the view plane, each end behind in turn
        send_seg(make_seg(-32'sh40_0000, 32'sh80_0000, 32'sh40_0000, -32'sh40_0000, 4));
        send_seg(make_seg(32'sh40_0000, 32'sh80_0000, -32'sh40_0000, -32'sh40_0000, 5));
        send_seg(make_seg(-32'sh40_0000, -32'sh40_0000, 32'sh40_0000, 32'sh80_0000, 6));
        send_seg(make_seg(32'sh40_0000, -32'sh40_0000, -32'sh40_0000, 32'sh80_0000, 7));
        // touching end with the other behind
        send_seg(make_seg(32'sh10_0000, 0, 32'sh20_0000, -32'sh10_0000, 8));
        send_seg(make_seg(32'sh10_0000, -32'sh10_0000, 32'sh20_0000, 32'sh0_8000, 9));
        // both behind, off screen, extreme crossing
        send_seg(make_seg(32'sh10_0000, -32'sh10_0000, 32'sh20_0000, -32'sh20_0000, 10));
        send_seg(make_seg(32'sh7000_0000, 32'sh1_0000, 32'sh7fff_0000, 32'sh1_0000, 11));
        send_seg(make_seg(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 12));
        send_seg(make_seg(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 13));
        drain();
    endtask

    task automatic test_random_default();
        sender_idle_ok = 1;
        rx_idle_ok = 1;
        send_random(450);
        sender_idle_ok = 0;
        rx_idle_ok = 0;
        send_random(50);    // back-to-back, no stalls
        drain();
    endtask

    task automatic test_config_sweep();
        sender_idle_ok = 1;
        rx_idle_ok = 1;
        set_view(0, -1, 0, 32'h8000_0000, 0);
        send_random(150);
        drain();
        set_view(65535, -65535, 65535, 0, 32'h7fff_ffff);
        send_random(150);
        drain();
        set_view(65535, -1, 65535, 32'h8000_0000, 32'h7fff_ffff);
        send_random(150);
        drain();
        set_view(0, -65535, 1, 0, 0);
        send_random(150);
        drain();
        set_view(1000, -3000, 200, -4000000, 2500000);
        send_random(150);
        drain();
        set_view(256, -256, 64, -1310720, 1310720);
        send_random(150);
        drain();
    endtask

    task automatic test_backpressure();
        sender_idle_ok = 0;
        rx_idle_ok = 1;
        hold_req = 1;
        send_random(250);
        hold_req = 0;
        sender_idle_ok = 1;
        send_random(150);
        drain();
    endtask

    // receiver side: random stall, plus one long hold-off on request
    always @(negedge i_clk) begin
        int r;
        if (hold_req && !hold_taken) begin
            hold_taken = 1;
            hold_left  = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_res_stall = 1'b1;
        end else if (!rx_idle_ok) begin
            i_res_stall = 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            // now and then a longer stretch of stall
            if (r >= 98) begin
                hold_left   = $urandom_range(5, 30);
                i_res_stall = 1'b1;
            end else begin
                i_res_stall = (r < 25);
            end
        end
    end

    always @(posedge i_clk) begin
        t_seg_out e;
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (pending_res.size() == 0) begin
                $error("result item with none expected, tag %h", o_res.tag_out);
                n_errors++;
            end else begin
                e = pending_res.pop_front();
                if (o_res.visible !== e.visible) begin
                    $error("visible: expected %0d, got %0d", e.visible, o_res.visible);
                    n_errors++;
                end
                if (o_res.left_x !== e.left_x) begin
                    $error("left_x: expected %0d, got %0d", e.left_x, o_res.left_x);
                    n_errors++;
                end
                if (o_res.right_x !== e.right_x) begin
                    $error("right_x: expected %0d, got %0d", e.right_x, o_res.right_x);
                    n_errors++;
                end
                if (o_res.left_height !== e.left_height) begin
                    $error("left_height: expected %0d, got %0d",
                           e.left_height, o_res.left_height);
                    n_errors++;
                end
                if (o_res.right_height !== e.right_height) begin
                    $error("right_height: expected %0d, got %0d",
                           e.right_height, o_res.right_height);
                    n_errors++;
                end
                if (o_res.far_dist_sq !== e.far_dist_sq) begin
                    $error("far_dist_sq: expected %0d, got %0d",
                           e.far_dist_sq, o_res.far_dist_sq);
                    n_errors++;
                end
                if (o_res.near_dist_sq !== e.near_dist_sq) begin
                    $error("near_dist_sq: expected %0d, got %0d",
                           e.near_dist_sq, o_res.near_dist_sq);
                    n_errors++;
                end
                if (o_res.clip_side !== e.clip_side) begin
                    $error("clip_side: expected %0d, got %0d", e.clip_side, o_res.clip_side);
                    n_errors++;
                end
                if (o_res.tag_out !== e.tag_out) begin
                    $error("tag_out: expected %h, got %h", e.tag_out, o_res.tag_out);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        n_errors = 0;
        sender_idle_ok = 0;
        rx_idle_ok = 0;
        hold_req = 0;
        hold_taken = 0;
        hold_left = 0;
        i_rst_n = 1'b0;
        i_seg = '0;
        i_seg_valid = 1'b0;
        i_res_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        screen_dist = 256;
        vanish_ofs = -256;
        wall_ht = 64;
        scr_left = -1310720;
        scr_right = 1310720;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        pause_cycles(2);

        test_directed();
        test_random_default();
        test_config_sweep();
        test_backpressure();

        if (n_errors == 0 && pending_res.size() == 0) begin
            $display("status: pass");
        end else begin
            if (pending_res.size() != 0)
                $error("%0d expected result items never arrived", pending_res.size());
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/wsp_pkg.sv
rtl/wsp_div.sv
rtl/wall_segment_projector.sv
tb/tb_wall_segment_projector.sv
